// ----- hw/rtl/wdts_pkg.sv -----
// shared types and constants of the wavetable dds tone source
`timescale 1ns / 1ps

package wdts_pkg;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_START  = 2'd1,
		MODE_TICK   = 2'd2,
		MODE_SAMPLE = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  table_index;
		logic [15:0] table_value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] phase_step;
		logic [1:0]  sample_format;
		logic [31:0] tick_limit;
	} cfg_t;

	localparam logic [1:0] CFG_PHASE_STEP    = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_FORMAT = 2'd1;
	localparam logic [1:0] CFG_NOTE_LENGTH   = 2'd2;

	localparam logic [1:0] FMT_U8  = 2'd0;
	localparam logic [1:0] FMT_U16 = 2'd1;
	localparam logic [1:0] FMT_I16 = 2'd2;

	localparam logic [31:0] PHASE_STEP_RESET = 32'h0100_0000;
	localparam int unsigned PHASE_SHIFT      = 24;
	localparam int unsigned BYTE_SHIFT       = 8;
	localparam logic [15:0] OFFSET_BIN       = 16'h8000;

endpackage

// ----- hw/rtl/wdts_front.sv -----
// front end: accepts input words, decodes them and queues commands for the back end
`timescale 1ns / 1ps

module wdts_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         mode,
	input  logic [7:0]         table_index,
	input  logic [15:0]        table_value,
	output logic               head_valid,
	output wdts_pkg::cmd_t     head_cmd,
	input  logic               head_pop
);

	localparam logic [1:0] QUEUE_FULL = 2'd2;

	wdts_pkg::cmd_t cmd_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	wdts_pkg::cmd_t new_cmd;

	assign item_ready = (cnt_q != QUEUE_FULL);
	assign push       = item_valid && item_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = cmd_q[rptr_q];

	always_comb begin
		new_cmd.mode        = wdts_pkg::mode_t'(mode);
		new_cmd.table_index = table_index;
		new_cmd.table_value = table_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (head_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !head_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (head_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/wdts_back.sv -----
// back end: wavetable, phase and elapsed time, sample formatting and output queue
`timescale 1ns / 1ps

module wdts_back #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wdts_pkg::cfg_t     cfg,
	input  logic               head_valid,
	input  wdts_pkg::cmd_t     head_cmd,
	output logic               head_pop,
	output logic               sample_valid,
	input  logic               sample_ready,
	output logic [7:0]         left_sample,
	output logic [7:0]         right_sample
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [15:0]   mem [TABLE_DEPTH];
	logic [AW-1:0] angle_tab [256];

	logic [31:0]   phase_q;
	logic [31:0]   elapsed_q;
	logic          v_s1;
	logic [15:0]   rd_s1;

	logic [7:0]    buf_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    out_cnt_q;

	logic          is_sample;
	logic          emit_ok;
	logic          credit_ok;
	logic          out_fire;
	logic          emit;
	logic          mem_we;
	logic [AW+7:0] idx_wide;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [7:0]    phase_top;
	logic [15:0]   biased;
	logic [7:0]    pcm_s1;

	// top phase byte folded into the table depth
	for (genvar g = 0; g < 256; g++) begin : g_angle
		assign angle_tab[g] = AW'(g % TABLE_DEPTH);
	end

	assign phase_top = 8'(phase_q >> wdts_pkg::PHASE_SHIFT);
	assign rd_addr   = angle_tab[phase_top];
	assign idx_wide  = {{AW{1'b0}}, head_cmd.table_index};
	assign wr_addr   = idx_wide[AW-1:0];

	assign out_fire  = sample_valid && sample_ready;
	assign is_sample = (head_cmd.mode == wdts_pkg::MODE_SAMPLE);
	assign emit_ok   = (elapsed_q < cfg.tick_limit);
	// room for the word in flight plus this one
	assign credit_ok = ({1'b0, out_cnt_q} + {2'b00, v_s1}) < (3'd2 + {2'b00, out_fire});
	assign head_pop  = head_valid && !(is_sample && emit_ok && !credit_ok);
	assign emit      = head_pop && is_sample && emit_ok;
	assign mem_we    = head_pop && (head_cmd.mode == wdts_pkg::MODE_LOAD) &&
		(idx_wide < (AW+8)'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= head_cmd.table_value;
		end
		if (emit) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 32'd0;
			elapsed_q <= 32'd0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= emit;
			if (head_pop) begin
				case (head_cmd.mode)
					wdts_pkg::MODE_START: begin
						phase_q   <= 32'd0;
						elapsed_q <= 32'd0;
					end
					wdts_pkg::MODE_TICK: begin
						if (elapsed_q != '1) begin
							elapsed_q <= elapsed_q + 32'd1;
						end
					end
					wdts_pkg::MODE_SAMPLE: begin
						if (emit_ok) begin
							phase_q <= phase_q + cfg.phase_step;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign biased = rd_s1 + wdts_pkg::OFFSET_BIN;

	always_comb begin
		case (cfg.sample_format)
			wdts_pkg::FMT_U16: pcm_s1 = 8'(rd_s1 >> wdts_pkg::BYTE_SHIFT);
			wdts_pkg::FMT_I16: pcm_s1 = 8'(biased >> wdts_pkg::BYTE_SHIFT);
			default:           pcm_s1 = rd_s1[7:0];
		endcase
	end

	// output word queue
	always_ff @(posedge clk) begin
		if (v_s1) begin
			buf_q[wptr_q] <= pcm_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= 1'b0;
			rptr_q    <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (v_s1) begin
				wptr_q <= ~wptr_q;
			end
			if (out_fire) begin
				rptr_q <= ~rptr_q;
			end
			if (v_s1 && !out_fire) begin
				out_cnt_q <= out_cnt_q + 2'd1;
			end else if (out_fire && !v_s1) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	assign sample_valid = (out_cnt_q != 2'd0);
	assign left_sample  = buf_q[rptr_q];
	assign right_sample = buf_q[rptr_q];

endmodule

// ----- hw/rtl/wavetable_dds_tone_source.sv -----
// top level of the wavetable dds tone source: config registers, front and back ends
//
//  channel   handshake                  payload
//  item      item_valid / item_ready    mode, table_index, table_value
//  sample    sample_valid / sample_ready left_sample, right_sample
//  config    cfg_we                     cfg_addr, cfg_data
//
// one word per cycle while the output is not stalled; a sample slot's word passes in turn through
// the command queue, the table read register and the output queue
// the table read is one synchronous memory port, the note limit is one 16x16 multiply at write
// reset clears queues, phase and elapsed time and sets config to its defaults; table contents stay undefined
// a stalled sample output fills a two-word output queue, then a two-word command queue,
// then item_ready drops
`timescale 1ns / 1ps

module wavetable_dds_tone_source #(
	parameter int unsigned TABLE_DEPTH    = 256,
	parameter int unsigned TICKS_PER_UNIT = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  table_index,
	input  logic [15:0] table_value,
	output logic        sample_valid,
	input  logic        sample_ready,
	output logic [7:0]  left_sample,
	output logic [7:0]  right_sample,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	wdts_pkg::cfg_t cfg_q;
	logic [31:0]    limit_d;
	logic           head_valid;
	wdts_pkg::cmd_t head_cmd;
	logic           head_pop;

	assign limit_d = {16'd0, cfg_data[15:0]} * {16'd0, 16'(TICKS_PER_UNIT)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step    <= wdts_pkg::PHASE_STEP_RESET;
			cfg_q.sample_format <= wdts_pkg::FMT_U8;
			cfg_q.tick_limit    <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				wdts_pkg::CFG_PHASE_STEP:    cfg_q.phase_step    <= cfg_data;
				wdts_pkg::CFG_SAMPLE_FORMAT: cfg_q.sample_format <= cfg_data[1:0];
				wdts_pkg::CFG_NOTE_LENGTH:   cfg_q.tick_limit    <= limit_d;
				default: begin
				end
			endcase
		end
	end

	wdts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.mode        (mode),
		.table_index (table_index),
		.table_value (table_value),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.head_pop    (head_pop)
	);

	wdts_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.head_pop     (head_pop),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

endmodule

// ----- hw/rtl/wdts_checker.sv -----
// port-level checker of the wavetable dds tone source and its bind
`timescale 1ns / 1ps

module wdts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        sample_valid,
	input logic        sample_ready,
	input logic [7:0]  left_sample,
	input logic [7:0]  right_sample
);

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid)
		else $error("sample word dropped while stalled");

	a_out_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> $stable(left_sample) && $stable(right_sample))
		else $error("sample word changed while stalled");

	a_channels_match: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> left_sample == right_sample)
		else $error("left and right samples differ");

	a_ready_after_reset: assert property (@(posedge clk)
		$past(!arst_n) && arst_n |-> item_ready)
		else $error("item_ready low after reset");

	a_no_word_in_reset: assert property (@(posedge clk)
		!arst_n |-> !sample_valid)
		else $error("sample word shown during reset");

endmodule

bind wavetable_dds_tone_source wdts_checker u_wdts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.left_sample  (left_sample),
	.right_sample (right_sample)
);
